### src/segi_pkg.sv
// shared constants, types and status codes for the segment intersection unit
`default_nettype none
package segi_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int THR_BITS   = 36;
  localparam int OUT_BITS   = 24;
  localparam int VEC_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * VEC_BITS;
  localparam int DET_BITS   = PROD_BITS + 1;
  localparam int ACC_BITS   = DET_BITS + 1;
  localparam int Q_BITS     = COORD_BITS + FRAC_BITS;
  localparam int NUM_CELLS  = Q_BITS;

  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_PARALLEL = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;

  // item state handed from cell to cell
  typedef struct packed {
    logic [1:0]                   status;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic                         neg_x;
    logic                         neg_y;
    logic [Q_BITS-1:0]            avx;
    logic [Q_BITS-1:0]            avy;
    logic [DET_BITS-1:0]          n;
    logic [DET_BITS-1:0]          d;
    logic [DET_BITS-1:0]          accx;
    logic [DET_BITS-1:0]          accy;
    logic [Q_BITS-1:0]            qx;
    logic [Q_BITS-1:0]            qy;
  } cell_t;

endpackage
`default_nettype wire

### src/segi_front.sv
// front stages: direction vectors, cross products, determinant test and range check
`default_nettype none
module segi_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [segi_pkg::THR_BITS-1:0]        thr,
  input  wire logic                                 up_valid,
  output logic                                      up_ready,
  input  wire logic [8*segi_pkg::COORD_BITS-1:0]    up_data,
  output logic                                      dn_valid,
  input  wire logic                                 dn_ready,
  output segi_pkg::cell_t                           dn_data
);

  localparam int CB = segi_pkg::COORD_BITS;
  localparam int VB = segi_pkg::VEC_BITS;
  localparam int PB = segi_pkg::PROD_BITS;
  localparam int DB = segi_pkg::DET_BITS;

  typedef struct packed {
    logic signed [CB-1:0] px, py;
    logic signed [VB-1:0] v1x, v1y, v2x, v2y, dx, dy;
  } s1_t;

  typedef struct packed {
    logic signed [CB-1:0] px, py;
    logic signed [VB-1:0] v1x, v1y;
    logic signed [PB-1:0] a, b, c, e, f, g;
  } s2_t;

  typedef struct packed {
    logic signed [CB-1:0] px, py;
    logic signed [VB-1:0] v1x, v1y;
    logic signed [DB-1:0] det, tn, un;
  } s3_t;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  segi_pkg::cell_t s4_r, s4_nxt;

  logic signed [CB-1:0] p1x, p1y, e1x, e1y, p2x, p2y, e2x, e2y;
  logic signed [DB-1:0] det_abs, tn_n, un_n;
  logic                 par, outside;
  logic signed [VB-1:0] abs_x, abs_y;

  // elastic handshake along the stages
  assign s4_rdy   = !s4_v_r || dn_ready;
  assign s3_rdy   = !s3_v_r || s4_rdy;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign up_ready = s1_rdy;
  assign dn_valid = s4_v_r;
  assign dn_data  = s4_r;

  // unpack coordinates
  assign p1x = up_data[0*CB +: CB];
  assign p1y = up_data[1*CB +: CB];
  assign e1x = up_data[2*CB +: CB];
  assign e1y = up_data[3*CB +: CB];
  assign p2x = up_data[4*CB +: CB];
  assign p2y = up_data[5*CB +: CB];
  assign e2x = up_data[6*CB +: CB];
  assign e2y = up_data[7*CB +: CB];

  // stage 1: differences
  always_comb begin
    s1_nxt.px  = p1x;
    s1_nxt.py  = p1y;
    s1_nxt.v1x = VB'(e1x) - VB'(p1x);
    s1_nxt.v1y = VB'(e1y) - VB'(p1y);
    s1_nxt.v2x = VB'(e2x) - VB'(p2x);
    s1_nxt.v2y = VB'(e2y) - VB'(p2y);
    s1_nxt.dx  = VB'(p2x) - VB'(p1x);
    s1_nxt.dy  = VB'(p2y) - VB'(p1y);
  end

  // stage 2: six products
  always_comb begin
    s2_nxt.px  = s1_r.px;
    s2_nxt.py  = s1_r.py;
    s2_nxt.v1x = s1_r.v1x;
    s2_nxt.v1y = s1_r.v1y;
    s2_nxt.a   = PB'(s1_r.v2x) * PB'(s1_r.v1y);
    s2_nxt.b   = PB'(s1_r.v1x) * PB'(s1_r.v2y);
    s2_nxt.c   = PB'(s1_r.v2x) * PB'(s1_r.dy);
    s2_nxt.e   = PB'(s1_r.dx)  * PB'(s1_r.v2y);
    s2_nxt.f   = PB'(s1_r.v1x) * PB'(s1_r.dy);
    s2_nxt.g   = PB'(s1_r.v1y) * PB'(s1_r.dx);
  end

  // stage 3: determinant and numerators
  always_comb begin
    s3_nxt.px  = s2_r.px;
    s3_nxt.py  = s2_r.py;
    s3_nxt.v1x = s2_r.v1x;
    s3_nxt.v1y = s2_r.v1y;
    s3_nxt.det = DB'(s2_r.a) - DB'(s2_r.b);
    s3_nxt.tn  = DB'(s2_r.c) - DB'(s2_r.e);
    s3_nxt.un  = DB'(s2_r.f) - DB'(s2_r.g);
  end

  // stage 4: sign normalise, parallel and range tests, set up the divider
  always_comb begin
    det_abs = s3_r.det[DB-1] ? -s3_r.det : s3_r.det;
    tn_n    = s3_r.det[DB-1] ? -s3_r.tn  : s3_r.tn;
    un_n    = s3_r.det[DB-1] ? -s3_r.un  : s3_r.un;
    par     = {1'b0, det_abs} <= (DB+1)'(thr);
    outside = tn_n[DB-1] || (tn_n > det_abs) || un_n[DB-1] || (un_n > det_abs);
    abs_x   = s3_r.v1x[VB-1] ? -s3_r.v1x : s3_r.v1x;
    abs_y   = s3_r.v1y[VB-1] ? -s3_r.v1y : s3_r.v1y;
    if (par) begin
      s4_nxt.status = segi_pkg::ST_PARALLEL;
    end else if (outside) begin
      s4_nxt.status = segi_pkg::ST_OUTSIDE;
    end else begin
      s4_nxt.status = segi_pkg::ST_HIT;
    end
    s4_nxt.px    = s3_r.px;
    s4_nxt.py    = s3_r.py;
    s4_nxt.neg_x = s3_r.v1x[VB-1];
    s4_nxt.neg_y = s3_r.v1y[VB-1];
    s4_nxt.avx   = {abs_x[CB-1:0], {segi_pkg::FRAC_BITS{1'b0}}};
    s4_nxt.avy   = {abs_y[CB-1:0], {segi_pkg::FRAC_BITS{1'b0}}};
    s4_nxt.n     = tn_n;
    s4_nxt.d     = det_abs;
    s4_nxt.accx  = '0;
    s4_nxt.accy  = '0;
    s4_nxt.qx    = '0;
    s4_nxt.qy    = '0;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= up_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
      if (s4_rdy) s4_v_r <= s3_v_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_rdy) s1_r <= s1_nxt;
    if (s2_rdy) s2_r <= s2_nxt;
    if (s3_rdy) s3_r <= s3_nxt;
    if (s4_rdy) s4_r <= s4_nxt;
  end

endmodule
`default_nettype wire

### src/segi_div_cell.sv
// one divider cell: a single quotient digit step for both coordinates
`default_nettype none
module segi_div_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire segi_pkg::cell_t up_data,
  output logic                 dn_valid,
  input  wire logic            dn_ready,
  output segi_pkg::cell_t      dn_data
);

  localparam int DB = segi_pkg::DET_BITS;
  localparam int AB = segi_pkg::ACC_BITS;
  localparam int QB = segi_pkg::Q_BITS;

  logic            v_r;
  segi_pkg::cell_t c_r, c_nxt;
  logic [AB-1:0]   tx, ty, dd, d2;
  logic [AB-1:0]   rx, ry;
  logic [1:0]      gx, gy;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = c_r;

  // shift in next multiplier bit, then subtract the divisor up to twice
  always_comb begin
    dd = {1'b0, up_data.d};
    d2 = {up_data.d, 1'b0};
    tx = {up_data.accx, 1'b0} + (up_data.avx[QB-1] ? AB'(up_data.n) : '0);
    ty = {up_data.accy, 1'b0} + (up_data.avy[QB-1] ? AB'(up_data.n) : '0);
    if (tx >= d2) begin
      rx = tx - d2;
      gx = 2'd2;
    end else if (tx >= dd) begin
      rx = tx - dd;
      gx = 2'd1;
    end else begin
      rx = tx;
      gx = 2'd0;
    end
    if (ty >= d2) begin
      ry = ty - d2;
      gy = 2'd2;
    end else if (ty >= dd) begin
      ry = ty - dd;
      gy = 2'd1;
    end else begin
      ry = ty;
      gy = 2'd0;
    end
    c_nxt      = up_data;
    c_nxt.avx  = {up_data.avx[QB-2:0], 1'b0};
    c_nxt.avy  = {up_data.avy[QB-2:0], 1'b0};
    c_nxt.accx = rx[DB-1:0];
    c_nxt.accy = ry[DB-1:0];
    c_nxt.qx   = {up_data.qx[QB-2:0], 1'b0} + QB'(gx);
    c_nxt.qy   = {up_data.qy[QB-2:0], 1'b0} + QB'(gy);
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (up_ready) c_r <= c_nxt;
  end

endmodule
`default_nettype wire

### src/segment_intersection.sv
// path from accepted item to result: 4 front stages, 24 divider cells, 1 output register
// throughput: one item per cycle unless out_tready stalls; 24 divider cells, one quotient digit each
// every stage is elastic, so a held result stalls only the stages behind it
// reset: synchronous active-low rst_n empties all stages and clears the threshold to 0
// top level of the segment intersection unit
`default_nettype none
module segment_intersection (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [segi_pkg::THR_BITS-1:0]       cfg_wr_data,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  wire logic [8*segi_pkg::COORD_BITS-1:0]   in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // cross_x, cross_y
  output logic [2*segi_pkg::OUT_BITS-1:0]          out_tdata,
  // status
  output logic [1:0]                               out_tuser
);

  localparam int NC = segi_pkg::NUM_CELLS;
  localparam int OB = segi_pkg::OUT_BITS;
  localparam int FB = segi_pkg::FRAC_BITS;

  logic [segi_pkg::THR_BITS-1:0] thr_r;
  logic            ch_valid [NC+1];
  logic            ch_ready [NC+1];
  segi_pkg::cell_t ch_data  [NC+1];

  logic                 out_v_r, last_rdy;
  logic [1:0]           st_r, st_nxt;
  logic [OB-1:0]        cx_r, cx_nxt, cy_r, cy_nxt;
  segi_pkg::cell_t      fin;
  logic [OB-1:0]        offx, offy;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  segi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .thr      (thr_r),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (in_tdata),
    .dn_valid (ch_valid[0]),
    .dn_ready (ch_ready[0]),
    .dn_data  (ch_data[0])
  );

  // divider chain
  for (genvar k = 0; k < NC; k++) begin : g_cell
    segi_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (ch_valid[k]),
      .up_ready (ch_ready[k]),
      .up_data  (ch_data[k]),
      .dn_valid (ch_valid[k+1]),
      .dn_ready (ch_ready[k+1]),
      .dn_data  (ch_data[k+1])
    );
  end

  assign last_rdy   = !out_v_r || out_tready;
  assign ch_ready[NC] = last_rdy;

  // floor rounding for negative direction, then add the start point for a hit; other results give zero
  always_comb begin
    fin    = ch_data[NC];
    offx   = fin.neg_x ? OB'(-(fin.qx + OB'(fin.accx != '0))) : OB'(fin.qx);
    offy   = fin.neg_y ? OB'(-(fin.qy + OB'(fin.accy != '0))) : OB'(fin.qy);
    st_nxt = fin.status;
    if (fin.status == segi_pkg::ST_HIT) begin
      cx_nxt = (OB'(fin.px) << FB) + offx;
      cy_nxt = (OB'(fin.py) << FB) + offy;
    end else begin
      cx_nxt = '0;
      cy_nxt = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (last_rdy) begin
      out_v_r <= ch_valid[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (last_rdy) begin
      st_r <= st_nxt;
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {cy_r, cx_r};
  assign out_tuser  = st_r;

endmodule
`default_nettype wire
